FILE: rtl/midi_track_recorder_macros.svh
// Assertion macros shared by the track recorder RTL.
`ifndef MIDI_TRACK_RECORDER_MACROS_SVH
`define MIDI_TRACK_RECORDER_MACROS_SVH

// Checked on every clock edge outside reset.
`define MTR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("track recorder assertion failed");

// Checked on every clock edge, reset included.
`define MTR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("track recorder assertion failed");

`endif

FILE: rtl/mtr_pkg.sv
// Types, constants and helper functions for the MIDI track recorder.
package mtr_pkg;

    localparam int SYSEX_CHUNK_DEF = 32;

    localparam logic [1:0] OP_CHAN  = 2'd0;
    localparam logic [1:0] OP_SYSEX = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    localparam logic [1:0] CFG_PORT_MASK = 2'd0;
    localparam logic [1:0] CFG_DFLT_EN   = 2'd1;
    localparam logic [1:0] CFG_TPQ       = 2'd2;
    localparam logic [1:0] CFG_TEMPO     = 2'd3;

    localparam logic [4:0]  PORT_DEFAULT = 5'd16;
    localparam logic [7:0]  B_REALTIME   = 8'hF8;
    localparam logic [7:0]  B_SYX_START  = 8'hF0;
    localparam logic [7:0]  B_SYX_END    = 8'hF7;
    localparam logic [7:0]  B_META       = 8'hFF;
    localparam logic [7:0]  B_TEMPO      = 8'h51;
    localparam logic [7:0]  B_EOT        = 8'h2F;
    localparam logic [7:0]  B_CONT       = 8'h80;
    localparam logic [27:0] DELTA_MAX    = 28'h0FFFFFFF;

    typedef enum logic [2:0] {
        K_START,
        K_STOP,
        K_CHAN,
        K_SYX_F0,
        K_SYX_BYTE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] tick;
        logic [7:0]  byte_v;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic        three;
    } t_cmd;

    typedef struct packed {
        logic [15:0] en_mask;
        logic        dflt_en;
        logic [15:0] tpq;
        logic [23:0] tempo;
    } t_cfg;

    // Index of the most significant nonzero 7-bit group of a delta.
    function automatic logic [1:0] vl_top(input logic [27:0] v);
        logic [1:0] g;
        if (v[27:21] != 7'd0)      g = 2'd3;
        else if (v[20:14] != 7'd0) g = 2'd2;
        else if (v[13:7] != 7'd0)  g = 2'd1;
        else                       g = 2'd0;
        return g;
    endfunction

endpackage

FILE: rtl/mtr_front.sv
// Front end: accepts input requests, drops unrecorded traffic, builds commands.
module mtr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtr_pkg::t_cfg   i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_op,
    input  logic [31:0]     i_tick,
    input  logic [4:0]      i_port_code,
    input  logic [7:0]      i_status_byte,
    input  logic [6:0]      i_data_first,
    input  logic [6:0]      i_data_second,
    input  logic            i_q_full,
    output logic            o_q_push,
    output mtr_pkg::t_cmd   o_q_data
);

    logic port_ok;
    logic keep;
    logic three;
    logic two;

    always_comb begin
        if (i_port_code == mtr_pkg::PORT_DEFAULT)
            port_ok = i_cfg.dflt_en;
        else if (i_port_code[4])
            port_ok = 1'b0;
        else
            port_ok = i_cfg.en_mask[i_port_code[3:0]];
    end

    always_comb begin
        three = 1'b0;
        two   = 1'b0;
        case (i_status_byte[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: three = 1'b1;
            4'hC, 4'hD:                   two   = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        o_q_data.tick   = i_tick;
        o_q_data.byte_v = i_status_byte;
        o_q_data.d1     = i_data_first;
        o_q_data.d2     = i_data_second;
        o_q_data.three  = three;
        keep            = 1'b1;
        unique case (i_op)
            mtr_pkg::OP_START: o_q_data.kind = mtr_pkg::K_START;
            mtr_pkg::OP_STOP:  o_q_data.kind = mtr_pkg::K_STOP;
            mtr_pkg::OP_CHAN: begin
                o_q_data.kind = mtr_pkg::K_CHAN;
                keep = port_ok && (i_status_byte < mtr_pkg::B_REALTIME) && (three || two);
            end
            default: begin
                o_q_data.kind = (i_status_byte == mtr_pkg::B_SYX_START) ?
                                mtr_pkg::K_SYX_F0 : mtr_pkg::K_SYX_BYTE;
                keep = port_ok && (i_status_byte < mtr_pkg::B_REALTIME);
            end
        endcase
    end

    // Requests, dropped or kept, are taken only while the queue has room.
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && keep;

endmodule

FILE: rtl/mtr_cmd_fifo.sv
// Two-entry command queue between front and back end.
module mtr_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtr_pkg::t_cmd   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output mtr_pkg::t_cmd   o_data,
    output logic            o_empty
);

    mtr_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= !r_wr;
            end
            if (i_pop)
                r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

FILE: rtl/mtr_back.sv
// Back end: recording state, SysEx store, byte sequencer and output register.
`include "midi_track_recorder_macros.svh"

module mtr_back #(
    parameter int SYSEX_CHUNK = mtr_pkg::SYSEX_CHUNK_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtr_pkg::t_cfg   i_cfg,
    input  logic            i_q_empty,
    input  mtr_pkg::t_cmd   i_q_data,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_track_byte,
    output logic            o_run_last,
    output logic [31:0]     o_track_length
);

    localparam int AW = $clog2(SYSEX_CHUNK);
    localparam int FW = $clog2(SYSEX_CHUNK + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_START, S_VL, S_FL_START, S_FL_HDR, S_FL_LEN,
        S_FL_RD, S_FL_DATA, S_CHAN, S_CHAN_MSG, S_F0, S_STORE, S_EOT,
        S_MOD, S_EOT_VL
    } t_state;

    t_state         r_state;
    t_state         r_ret;
    t_state         r_vl_ret;
    mtr_pkg::t_cmd  r_cmd;
    logic           r_rec;
    logic [31:0]    r_prev;
    logic [27:0]    r_pend;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  r_idx;
    logic           r_f0;
    logic           r_fl_last;
    logic [31:0]    r_bw;
    logic [27:0]    r_vl;
    logic [1:0]     r_grp;
    logic [2:0]     r_cnt;
    logic [17:0]    r_rem;
    logic [31:0]    r_dvd;
    logic [4:0]     r_mcnt;
    logic           r_ovalid;
    logic [7:0]     r_obyte;
    logic           r_olast;
    logic [31:0]    r_olen;
    logic [7:0]     r_mem [SYSEX_CHUNK];
    logic [7:0]     r_rd_data;

    logic           can_emit;
    logic           e_req;
    logic [7:0]     e_byte;
    logic           e_last;
    logic           fire;
    logic [27:0]    delta;
    logic [31:0]    tdiff;
    logic [15:0]    tpq_eff;
    logic [17:0]    bar;
    logic [18:0]    rem_t;
    logic [6:0]     vl_part;
    logic           need_flush;

    assign tpq_eff = (i_cfg.tpq == 16'd0) ? 16'd1 : i_cfg.tpq;
    assign bar     = {tpq_eff, 2'b00};
    assign rem_t   = {r_rem, r_dvd[31]};
    assign tdiff   = (r_cmd.tick >= r_prev) ? (r_cmd.tick - r_prev) : 32'd0;
    assign delta   = (tdiff[31:28] != 4'd0) ? mtr_pkg::DELTA_MAX : tdiff[27:0];

    always_comb begin
        case (r_grp)
            2'd3:    vl_part = r_vl[27:21];
            2'd2:    vl_part = r_vl[20:14];
            2'd1:    vl_part = r_vl[13:7];
            default: vl_part = r_vl[6:0];
        endcase
    end

    always_comb begin
        case (r_cmd.kind)
            mtr_pkg::K_SYX_BYTE: need_flush = (r_fill >= FW'(SYSEX_CHUNK));
            default:             need_flush = (r_fill != '0);
        endcase
    end

    // Byte offered to the output register in the current state.
    always_comb begin
        e_req  = 1'b1;
        e_byte = 8'h00;
        e_last = 1'b0;
        case (r_state)
            S_START: begin
                e_last = (r_cnt == 3'd6);
                case (r_cnt)
                    3'd0:    e_byte = 8'h00;
                    3'd1:    e_byte = mtr_pkg::B_META;
                    3'd2:    e_byte = mtr_pkg::B_TEMPO;
                    3'd3:    e_byte = 8'h03;
                    3'd4:    e_byte = i_cfg.tempo[23:16];
                    3'd5:    e_byte = i_cfg.tempo[15:8];
                    default: e_byte = i_cfg.tempo[7:0];
                endcase
            end
            S_VL:      e_byte = {(r_grp != 2'd0), vl_part};
            S_FL_HDR:  e_byte = r_f0 ? mtr_pkg::B_SYX_START : mtr_pkg::B_SYX_END;
            S_FL_LEN: begin
                e_byte = r_f0 ? 8'(r_fill - FW'(1)) : 8'(r_fill);
                e_last = r_fl_last && (r_idx == r_fill);
            end
            S_FL_DATA: begin
                e_byte = r_rd_data;
                e_last = r_fl_last && (r_idx + FW'(1) == r_fill);
            end
            S_CHAN_MSG: begin
                e_last = (r_cnt == (r_cmd.three ? 3'd2 : 3'd1));
                case (r_cnt)
                    3'd0:    e_byte = r_cmd.byte_v;
                    3'd1:    e_byte = {1'b0, r_cmd.d1};
                    default: e_byte = {1'b0, r_cmd.d2};
                endcase
            end
            S_EOT_VL: e_req = 1'b0;
            default: e_req = 1'b0;
        endcase
    end

    // EOT message bytes share the message state through the kind check.
    logic eot_msg;
    assign eot_msg  = (r_state == S_CHAN_MSG) && (r_cmd.kind == mtr_pkg::K_STOP);
    assign can_emit = !r_ovalid || i_out_ready;
    assign fire     = e_req && can_emit;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    logic [7:0] o_byte_mux;
    logic       o_last_mux;
    always_comb begin
        o_byte_mux = e_byte;
        o_last_mux = e_last;
        if (eot_msg) begin
            o_last_mux = (r_cnt == 3'd2);
            case (r_cnt)
                3'd0:    o_byte_mux = mtr_pkg::B_META;
                3'd1:    o_byte_mux = mtr_pkg::B_EOT;
                default: o_byte_mux = 8'h00;
            endcase
        end
    end

    // SysEx store.
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE)
            r_mem[r_fill[AW-1:0]] <= r_cmd.byte_v;
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rec    <= 1'b0;
            r_prev   <= 32'd0;
            r_pend   <= 28'd0;
            r_fill   <= '0;
            r_bw     <= 32'd0;
            r_ovalid <= 1'b0;
            r_f0     <= 1'b0;
        end else begin
            if (fire) begin
                r_ovalid <= 1'b1;
                r_obyte  <= o_byte_mux;
                r_olast  <= o_last_mux;
                r_olen   <= r_bw + 32'd1;
                r_bw     <= r_bw + 32'd1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_q_data;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_cmd.kind == mtr_pkg::K_START) begin
                        if (!r_rec) begin
                            r_rec   <= 1'b1;
                            r_prev  <= 32'd0;
                            r_fill  <= '0;
                            r_pend  <= 28'd0;
                            r_bw    <= 32'd0;
                            r_cnt   <= 3'd0;
                            r_state <= S_START;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_rec) begin
                        case (r_cmd.kind)
                            mtr_pkg::K_STOP:    r_ret <= S_EOT;
                            mtr_pkg::K_CHAN:    r_ret <= S_CHAN;
                            mtr_pkg::K_SYX_F0:  r_ret <= S_F0;
                            default:            r_ret <= S_STORE;
                        endcase
                        case (r_cmd.kind)
                            mtr_pkg::K_SYX_F0:   r_fl_last <= 1'b1;
                            mtr_pkg::K_SYX_BYTE:
                                r_fl_last <= (r_cmd.byte_v != mtr_pkg::B_SYX_END);
                            default:             r_fl_last <= 1'b0;
                        endcase
                        if (need_flush)
                            r_state <= S_FL_START;
                        else
                            case (r_cmd.kind)
                                mtr_pkg::K_STOP:   r_state <= S_EOT;
                                mtr_pkg::K_CHAN:   r_state <= S_CHAN;
                                mtr_pkg::K_SYX_F0: r_state <= S_F0;
                                default:           r_state <= S_STORE;
                            endcase
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_START: begin
                    if (fire) begin
                        r_cnt <= r_cnt + 3'd1;
                        if (r_cnt == 3'd6)
                            r_state <= S_IDLE;
                    end
                end
                S_VL: begin
                    if (fire) begin
                        if (r_grp == 2'd0)
                            r_state <= r_vl_ret;
                        else
                            r_grp <= r_grp - 2'd1;
                    end
                end
                S_FL_START: begin
                    r_vl     <= r_pend;
                    r_grp    <= mtr_pkg::vl_top(r_pend);
                    r_pend   <= 28'd0;
                    r_vl_ret <= S_FL_HDR;
                    r_idx    <= r_f0 ? FW'(1) : FW'(0);
                    r_state  <= S_VL;
                end
                S_FL_HDR: if (fire) r_state <= S_FL_LEN;
                S_FL_LEN: begin
                    if (fire) begin
                        if (r_idx == r_fill) begin
                            r_fill  <= '0;
                            r_state <= r_ret;
                        end else begin
                            r_state <= S_FL_RD;
                        end
                    end
                end
                S_FL_RD: r_state <= S_FL_DATA;
                S_FL_DATA: begin
                    if (fire) begin
                        if (r_idx + FW'(1) == r_fill) begin
                            r_fill  <= '0;
                            r_state <= r_ret;
                        end else begin
                            r_idx   <= r_idx + FW'(1);
                            r_state <= S_FL_RD;
                        end
                    end
                end
                S_CHAN: begin
                    r_vl     <= delta;
                    r_grp    <= mtr_pkg::vl_top(delta);
                    r_vl_ret <= S_CHAN_MSG;
                    r_cnt    <= 3'd0;
                    r_state  <= S_VL;
                end
                S_CHAN_MSG: begin
                    if (fire) begin
                        r_cnt <= r_cnt + 3'd1;
                        if (o_last_mux) begin
                            r_state <= S_IDLE;
                            if (eot_msg)
                                r_rec <= 1'b0;
                            else
                                r_prev <= r_cmd.tick;
                        end
                    end
                end
                S_F0: begin
                    r_fill  <= FW'(1);
                    r_f0    <= 1'b1;
                    r_pend  <= delta;
                    r_prev  <= r_cmd.tick;
                    r_state <= S_IDLE;
                end
                S_STORE: begin
                    r_fill <= r_fill + FW'(1);
                    if (r_fill == '0)
                        r_f0 <= 1'b0;
                    if (r_cmd.byte_v == mtr_pkg::B_SYX_END) begin
                        r_fl_last <= 1'b1;
                        r_ret     <= S_IDLE;
                        r_state   <= S_FL_START;
                    end else begin
                        r_state   <= S_IDLE;
                    end
                end
                S_EOT: begin
                    r_rem   <= 18'd0;
                    r_dvd   <= r_prev;
                    r_mcnt  <= 5'd0;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // restoring remainder, one dividend bit per cycle
                    r_rem   <= (rem_t >= {1'b0, bar}) ? 18'(rem_t - {1'b0, bar}) : rem_t[17:0];
                    r_dvd   <= {r_dvd[30:0], 1'b0};
                    r_mcnt  <= r_mcnt + 5'd1;
                    if (r_mcnt == 5'd31)
                        r_state <= S_EOT_VL;
                end
                S_EOT_VL: begin
                    r_vl     <= 28'(bar - r_rem);
                    r_grp    <= mtr_pkg::vl_top(28'(bar - r_rem));
                    r_vl_ret <= S_CHAN_MSG;
                    r_cnt    <= 3'd0;
                    r_state  <= S_VL;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_track_byte   = r_obyte;
    assign o_run_last     = r_olast;
    assign o_track_length = r_olen;

    `MTR_ASSERT(a_fill_max, r_fill <= FW'(SYSEX_CHUNK))
    `MTR_ASSERT(a_idle_empty, !r_rec |-> (r_fill == '0))
    `MTR_ASSERT(a_mod_rec, (r_state == S_MOD) |-> r_rec)
    `MTR_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !r_ovalid)

endmodule

FILE: rtl/midi_track_recorder.sv
// Top level of the MIDI track recorder: config registers, front, queue, back.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | op, tick, port_code, status, data
//  output  | out       | o_out_valid / i_out_ready | track_byte, run_last, track_length
//  config  | in        | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// Each request is classified combinationally and queued; dropped requests leave
// no trace. The back end takes a new command only once the last is done and
// sends its bytes through a registered output: a channel message may first
// flush pending SysEx, a flush reads the store through a registered read, and
// stop computes the bar remainder bit-serially. Reset is synchronous, active
// low, and resets the state machines, queue pointers, configuration and
// recording flags; the SysEx store needs no clearing. Output stalls hold the
// byte sequencer; the two-entry queue takes requests meanwhile until full.
module midi_track_recorder #(
    parameter int SYSEX_CHUNK = mtr_pkg::SYSEX_CHUNK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_tick,
    input  logic [4:0]  i_port_code,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_data_first,
    input  logic [6:0]  i_data_second,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_track_byte,
    output logic        o_run_last,
    output logic [31:0] o_track_length
);

    mtr_pkg::t_cfg r_cfg;
    mtr_pkg::t_cmd q_in;
    mtr_pkg::t_cmd q_out;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en_mask <= 16'd0;
            r_cfg.dflt_en <= 1'b0;
            r_cfg.tpq     <= 16'd96;
            r_cfg.tempo   <= 24'd500000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtr_pkg::CFG_PORT_MASK: r_cfg.en_mask <= i_cfg_data[15:0];
                mtr_pkg::CFG_DFLT_EN:   r_cfg.dflt_en <= i_cfg_data[0];
                mtr_pkg::CFG_TPQ:       r_cfg.tpq     <= i_cfg_data[15:0];
                default:                r_cfg.tempo   <= i_cfg_data;
            endcase
        end
    end

    mtr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_tick        (i_tick),
        .i_port_code   (i_port_code),
        .i_status_byte (i_status_byte),
        .i_data_first  (i_data_first),
        .i_data_second (i_data_second),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    mtr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    mtr_back #(.SYSEX_CHUNK(SYSEX_CHUNK)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_track_byte   (o_track_byte),
        .o_run_last     (o_run_last),
        .o_track_length (o_track_length)
    );

endmodule
